// ===== sv/escape_string_decoder_macros.svh =====
// Assertion macros shared by the escape string decoder RTL.
`ifndef ESCAPE_STRING_DECODER_MACROS_SVH
`define ESCAPE_STRING_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/esd_pkg.sv =====
// Shared types, constants and the escape lookup for the escape string decoder.
package esd_pkg;

    localparam int unsigned ESD_QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CARET_MASK  = 8'h1F;
    localparam logic [7:0] TERM_BYTE   = 8'h00;

    // Up to three result bytes produced by one input byte
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0]      lasts;
        logic [2:0][7:0] bytes;
    } esd_bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } esd_q_status_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } esd_esc_t;

    function automatic esd_esc_t esc_lookup(input logic [7:0] b);
        esd_esc_t r;
        r.hit   = 1'b1;
        r.value = b;
        unique case (b)
            8'h45:   r.value = 8'h1B;   // E -> ESC
            8'h5E:   r.value = 8'h5E;   // ^
            8'h5C:   r.value = 8'h5C;   // backslash
            8'h3A:   r.value = 8'h3A;   // :
            8'h6E:   r.value = 8'h0A;   // n -> LF
            8'h72:   r.value = 8'h0D;   // r -> CR
            8'h74:   r.value = 8'h09;   // t -> TAB
            8'h62:   r.value = 8'h08;   // b -> BS
            8'h66:   r.value = 8'h0C;   // f -> FF
            default: r.hit   = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

endpackage

// ===== sv/esd_front.sv =====
// Front end: tracks escape state and turns each input byte into a result bundle.
module esd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  esd_pkg::esd_q_status_t q_status,
    output logic                  q_push,
    output esd_pkg::esd_bundle_t  q_data
);
    import esd_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_CARET,
        MODE_BSLASH,
        MODE_OCTAL
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] oval_reg, oval_next;
    logic [1:0] odig_reg, odig_next;

    logic       accept;
    logic [3:0] cand_v;
    logic [7:0] cand_b [4];
    logic [3:0] digit;
    logic [7:0] merged;
    logic [1:0] dig_inc;
    esd_esc_t   esc;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign digit    = 4'(in_byte - CHAR_ZERO);
    assign merged   = {oval_reg[4:0], 3'b000} | {4'b0000, digit};
    assign dig_inc  = odig_reg + 2'd1;
    assign esc      = esc_lookup(in_byte);

    // Candidates: primary result, byte after an octal flush, flush at end, terminator
    always_comb
    begin
        mode_next = mode_reg;
        oval_next = oval_reg;
        odig_next = odig_reg;
        cand_v    = 4'b0000;
        cand_b[0] = in_byte;
        cand_b[1] = in_byte;
        cand_b[2] = oval_reg;
        cand_b[3] = TERM_BYTE;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (in_byte == CHAR_CARET)
                    mode_next = MODE_CARET;
                else if (in_byte == CHAR_BSLASH)
                    mode_next = MODE_BSLASH;
                else
                    cand_v[0] = 1'b1;
            end
            MODE_CARET:
            begin
                cand_v[0] = 1'b1;
                cand_b[0] = in_byte & CARET_MASK;
                mode_next = MODE_NORMAL;
            end
            MODE_BSLASH:
            begin
                mode_next = MODE_NORMAL;
                if (esc.hit)
                begin
                    cand_v[0] = 1'b1;
                    cand_b[0] = esc.value;
                end
                else if (is_digit(in_byte))
                begin
                    oval_next = {4'b0000, digit};
                    odig_next = 2'd1;
                    mode_next = MODE_OCTAL;
                end
                else
                    cand_v[0] = 1'b1;
            end
            MODE_OCTAL:
            begin
                if (is_digit(in_byte))
                begin
                    if (dig_inc == 2'd3 || dig_inc == 2'd0)
                    begin
                        cand_v[0] = 1'b1;
                        cand_b[0] = merged;
                        mode_next = MODE_NORMAL;
                        oval_next = '0;
                        odig_next = '0;
                    end
                    else
                    begin
                        oval_next = merged;
                        odig_next = dig_inc;
                    end
                end
                else
                begin
                    // flush the value, then decode this byte as a plain one
                    cand_v[0] = 1'b1;
                    cand_b[0] = oval_reg;
                    mode_next = MODE_NORMAL;
                    oval_next = '0;
                    odig_next = '0;
                    if (in_byte == CHAR_CARET)
                        mode_next = MODE_CARET;
                    else if (in_byte == CHAR_BSLASH)
                        mode_next = MODE_BSLASH;
                    else
                        cand_v[1] = 1'b1;
                end
            end
            default:
                mode_next = MODE_NORMAL;
        endcase
        if (in_last)
        begin
            cand_v[2] = (mode_next == MODE_OCTAL);
            cand_b[2] = oval_next;
            cand_v[3] = 1'b1;
            mode_next = MODE_NORMAL;
            oval_next = '0;
            odig_next = '0;
        end
    end

    // Pack the present candidates into consecutive slots
    always_comb
    begin
        logic [1:0] slot;
        slot         = 2'd0;
        q_data.bytes = '0;
        q_data.lasts = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (cand_v[k] && slot != 2'd3)
            begin
                q_data.bytes[slot] = cand_b[k];
                q_data.lasts[slot] = (k == 3);
                slot = slot + 2'd1;
            end
        end
        q_data.count = slot;
    end

    assign q_push = accept && (q_data.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            oval_reg <= '0;
            odig_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            oval_reg <= oval_next;
            odig_reg <= odig_next;
        end
    end

endmodule

// ===== sv/esd_queue.sv =====
// Short register queue of result bundles between front and back.
module esd_queue #(
    parameter int unsigned DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  esd_pkg::esd_bundle_t   push_data,
    input  logic                   pop,
    output esd_pkg::esd_bundle_t   pop_data,
    output esd_pkg::esd_q_status_t status
);
    import esd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    esd_bundle_t        store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/esd_back.sv =====
// Back end: unpacks result bundles onto the output channel one byte at a time.
module esd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  esd_pkg::esd_q_status_t q_status,
    input  esd_pkg::esd_bundle_t   q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   out_last
);
    import esd_pkg::*;

    esd_bundle_t bundle_reg;
    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic        final_slot;
    logic        out_accept;

    assign out_valid  = valid_reg;
    assign out_byte   = bundle_reg.bytes[idx_reg];
    assign out_last   = bundle_reg.lasts[idx_reg];
    assign out_accept = valid_reg && !out_stall;
    assign final_slot = (idx_reg == bundle_reg.count - 2'd1);
    assign q_pop      = !q_status.empty && (!valid_reg || (out_accept && final_slot));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_accept)
        begin
            // advance within the bundle, drop valid after its final byte
            if (final_slot)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            bundle_reg <= q_data;
    end

endmodule

// ===== sv/escape_string_decoder.sv =====
// Escape string decoder: raw key-mapping bytes in, decoded bytes out.
//
// Input channel (in_valid/in_stall, in_byte, in_last) takes one raw byte per
// transaction; in_last marks the final byte of a string. Output channel
// (out_valid/out_stall, out_byte, out_last) gives the decoded bytes, then a
// zero byte with out_last set that closes the string.
// A byte gives zero to three output bytes. The front end decodes it in the
// cycle it is taken and pushes the results as one bundle into a queue of
// QUEUE_DEPTH bundles; the back end plays a bundle out one byte per cycle
// while out_stall is low. A byte's first result passes the queue register,
// then the back end output register. Throughput: one input byte per cycle
// while each gives at most one result and the output is not stalled; a byte
// with more results keeps the back end's single output register busy.
// in_stall rises only when the queue is full. A stalled output holds its
// byte; the front keeps taking input until the queue fills.
// Reset clears the escape state, the queue and the output valid.
`include "escape_string_decoder_macros.svh"

module escape_string_decoder #(
    parameter int unsigned QUEUE_DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import esd_pkg::*;

    esd_q_status_t q_status;
    esd_bundle_t   push_data;
    esd_bundle_t   pop_data;
    logic          q_push;
    logic          q_pop;

    esd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    esd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    `ESD_ASSERT_NOW(a_no_push_full, q_status.full, !q_push, "push into full queue")
    `ESD_ASSERT_NOW(a_no_pop_empty, q_status.empty, !q_pop, "pop from empty queue")
    `ESD_ASSERT_NOW(a_term_zero, out_valid && out_last, out_byte == TERM_BYTE, "terminator not zero")
    `ESD_ASSERT_NEXT(a_last_in_pushes, in_valid && !in_stall && in_last, !q_status.empty, "string end lost")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the escape string decoder: random strings, byte-level checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int RANDOM_BYTES = 250;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_AFTER_CARET,
        MODE_AFTER_BSLASH,
        MODE_OCTAL_DIGITS
    } decode_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic       term;
    } dec_byte_t;

    // Letters that form a two-byte escape after a backslash
    localparam logic [7:0] ESC_LETTERS [9] = '{8'h45, 8'h5E, 8'h5C, 8'h3A, 8'h6E,
                                               8'h72, 8'h74, 8'h62, 8'h66};

    // Predicts decoded bytes from raw bytes and checks what the block returns
    class decoded_byte_board;
        dec_byte_t    decoded_q[$];
        decode_mode_t mode;
        logic [7:0]   oct_val;
        logic [1:0]   oct_cnt;
        int           errors;
        int           checked;
        int           strings;

        function new();
            clear_state();
            errors  = 0;
            checked = 0;
            strings = 0;
        endfunction

        function void clear_state();
            mode    = MODE_PLAIN;
            oct_val = 8'h00;
            oct_cnt = 2'd0;
        endfunction

        function void push_decoded(input logic [7:0] v, input logic term);
            dec_byte_t e;
            e.value = v;
            e.term  = term;
            decoded_q.push_back(e);
        endfunction

        function bit is_numeral(input logic [7:0] b);
            return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        endfunction

        function bit escape_code(input logic [7:0] b, output logic [7:0] v);
            v = b;
            case (b)
                8'h45: v = 8'h1B;                // E -> ESC
                8'h6E: v = 8'h0A;                // n -> LF
                8'h72: v = 8'h0D;                // r -> CR
                8'h74: v = 8'h09;                // t -> TAB
                8'h62: v = 8'h08;                // b -> BS
                8'h66: v = 8'h0C;                // f -> FF
                8'h5E, 8'h5C, 8'h3A: v = b;     // ^ \ : stand for themselves
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void plain_byte(input logic [7:0] b);
            if (b == CHAR_CARET)
                mode = MODE_AFTER_CARET;
            else if (b == CHAR_BSLASH)
                mode = MODE_AFTER_BSLASH;
            else
                push_decoded(b, 1'b0);
        endfunction

        function void note_raw(input logic [7:0] b, input logic is_end);
            logic [7:0] d;
            logic [7:0] v;
            d = b - CHAR_ZERO;
            case (mode)
                MODE_AFTER_CARET:
                begin
                    push_decoded(b & CARET_MASK, 1'b0);
                    mode = MODE_PLAIN;
                end
                MODE_AFTER_BSLASH:
                begin
                    mode = MODE_PLAIN;
                    if (escape_code(b, v))
                        push_decoded(v, 1'b0);
                    else if (is_numeral(b))
                    begin
                        oct_val = d;
                        oct_cnt = 2'd1;
                        mode    = MODE_OCTAL_DIGITS;
                    end
                    else
                        push_decoded(b, 1'b0);
                end
                MODE_OCTAL_DIGITS:
                begin
                    if (is_numeral(b))
                    begin
                        oct_val = (oct_val << 3) | d;
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3 || oct_cnt == 2'd0)
                        begin
                            push_decoded(oct_val, 1'b0);
                            clear_state();
                        end
                    end
                    else
                    begin
                        // Emit the short octal value, then decode this byte afresh
                        push_decoded(oct_val, 1'b0);
                        clear_state();
                        plain_byte(b);
                    end
                end
                default: plain_byte(b);
            endcase
            if (is_end)
            begin
                if (mode == MODE_OCTAL_DIGITS)
                    push_decoded(oct_val, 1'b0);
                push_decoded(TERM_BYTE, 1'b1);
                clear_state();
                strings++;
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_decoded(input logic [7:0] v, input logic term);
            dec_byte_t e;
            checked++;
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last=%0b", v, term));
            else
            begin
                e = decoded_q.pop_front();
                if (v !== e.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", v, e.value));
                if (term !== e.term)
                    report_mismatch($sformatf("out_last %0b, expected %0b", term, e.term));
            end
        endtask

        function int pending();
            return decoded_q.size();
        endfunction

        task close_out();
            if (decoded_q.size() != 0)
                report_mismatch($sformatf("%0d decoded bytes never arrived", decoded_q.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;

    decoded_byte_board board;
    bit  no_idle;
    int  raw_count;
    int  directed_count;
    int  cycles;

    escape_string_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one raw byte and hold it until the block takes it
    task automatic send_raw(input logic [7:0] b, input logic is_end);
        int gap;
        bit taken;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        in_last  = is_end;
        do
        begin
            @(posedge clk);
            taken = !in_stall;
            if (taken)
                board.note_raw(b, is_end);
            @(negedge clk);
        end while (!taken);
        raw_count++;
    endtask

    task automatic run_directed();
        send_raw(8'h00, 1'b0);                  // zero byte is plain data
        send_raw(8'hFF, 1'b0);
        send_raw(CHAR_CARET, 1'b0);             // caret on '@' gives 0
        send_raw(8'h40, 1'b0);
        send_raw(CHAR_CARET, 1'b0);             // caret on all-ones keeps five bits
        send_raw(8'hFF, 1'b0);
        send_raw(CHAR_BSLASH, 1'b0);
        send_raw(8'h45, 1'b0);
        send_raw(CHAR_BSLASH, 1'b0);            // three digits, truncated to a byte
        send_raw(8'h37, 1'b0);
        send_raw(8'h37, 1'b0);
        send_raw(8'h37, 1'b0);
        send_raw(CHAR_BSLASH, 1'b0);            // short octal cut off by a caret
        send_raw(8'h31, 1'b0);
        send_raw(CHAR_CARET, 1'b0);
        send_raw(8'h5B, 1'b0);
        send_raw(CHAR_BSLASH, 1'b0);            // unknown escape passes through
        send_raw(8'h78, 1'b0);
        send_raw(CHAR_BSLASH, 1'b0);            // pending digit flushed at the end
        send_raw(8'h39, 1'b1);
        send_raw(CHAR_BSLASH, 1'b0);            // octal, plain byte and terminator at once
        send_raw(8'h32, 1'b0);
        send_raw(8'h41, 1'b1);
        send_raw(CHAR_CARET, 1'b1);             // dangling caret
        send_raw(CHAR_BSLASH, 1'b1);            // dangling backslash
        send_raw(8'h71, 1'b1);
    endtask

    // Build one string from mostly well-formed pieces with some noise
    task automatic run_random_string();
        logic [7:0] raw_q[$];
        int         target;
        int         pick;
        int         ndig;
        target  = $urandom_range(1, 12);
        no_idle = ($urandom_range(0, 3) == 0);
        while (raw_q.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                raw_q.push_back(8'($urandom_range(0, 255)));
            else if (pick < 45)
            begin
                raw_q.push_back(CHAR_CARET);
                raw_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 70)
            begin
                raw_q.push_back(CHAR_BSLASH);
                raw_q.push_back(ESC_LETTERS[$urandom_range(0, 8)]);
            end
            else if (pick < 90)
            begin
                raw_q.push_back(CHAR_BSLASH);
                ndig = $urandom_range(1, 3);
                repeat (ndig) raw_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: raw_q.push_back(CHAR_CARET);
                    1: raw_q.push_back(CHAR_BSLASH);
                    default: raw_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
        end
        foreach (raw_q[i])
            send_raw(raw_q[i], i == raw_q.size() - 1);
    endtask

    // Output side: draw a stall per result, then take one transaction
    initial
    begin
        int  hold;
        bit  got;
        out_stall = 1'b0;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do
            begin
                @(posedge clk);
                got = out_valid;
                if (got)
                    board.check_decoded(out_byte, out_last);
                @(negedge clk);
            end while (!got);
        end
    end

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        no_idle   = 1'b0;
        raw_count = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        directed_count = raw_count;
        while (raw_count - directed_count < RANDOM_BYTES)
            run_random_string();
        in_valid = 1'b0;
        no_idle  = 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        board.close_out();

        $display("Covered %0d strings from %0d raw bytes (%0d directed), %0d decoded bytes checked",
                 board.strings, raw_count, directed_count, board.checked);
        $display("Escapes, caret codes, octal runs and dangling prefixes under random stalls");
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== escape_string_decoder.f =====
+incdir+sv
sv/esd_pkg.sv
sv/esd_front.sv
sv/esd_queue.sv
sv/esd_back.sv
sv/escape_string_decoder.sv
sim/tb.sv
